>>> rtl/pdta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdta_pkg
// Shared types and constants for the packed-decimal to ASCII unit.
// ----------------------------------------------------------------------------
package pdta_pkg;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   localparam logic [3:0] SIGN_NEG_B = 4'hB;
   localparam logic [3:0] SIGN_NEG_D = 4'hD;

   localparam logic [4:0] MAX_CHARS_RESET = 5'd18;

   // register indexes on the csr port
   localparam logic CSR_IDX_MAX_CHARS = 1'b0;

   // character generator sequence
   typedef enum logic [2:0] {
      GEN_SIGN,
      GEN_LEAD_POINT,
      GEN_DIGIT,
      GEN_ZERO,
      GEN_POINT,
      GEN_FLUSH
   } gen_state_type;

   // classified item, handed from the front to the back
   typedef struct packed {
      logic       neg;
      logic [3:0] prec;
      logic [3:0] radix;
   } item_ctl_type;

endpackage

>>> rtl/pdta_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdta_fifo
// Two-entry queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module pdta_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/pdta_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdta_front
// Accepts packed-decimal beats, clamps precision and scale, decodes the sign
// and aligns the digits, then queues the result for the back end.
// ----------------------------------------------------------------------------
module pdta_front
   import pdta_pkg::*;
#(
   parameter int MAX_DIGITS = 15
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [63:0]               packed_value,
   input  logic [3:0]                precision,
   input  logic [3:0]                scale,
   input  logic                      pop,
   output logic                      head_valid,
   output item_ctl_type              head_ctl,
   output logic [4*MAX_DIGITS-1:0]   head_digits
);

   localparam int DW = 4 * MAX_DIGITS;
   localparam int QW = $bits(item_ctl_type) + DW;
   localparam logic [3:0] MAX_PREC = 4'(MAX_DIGITS);

   logic [3:0]   prec;
   logic [3:0]   scale_clamp;
   logic [3:0]   sign_idx;
   logic [3:0]   sign_nib;
   logic [63:0]  aligned;
   item_ctl_type ctl;
   logic [DW-1:0] digits;
   logic [QW-1:0] q_rdata;
   logic          q_empty;

   always_comb begin
      prec        = (precision > MAX_PREC) ? MAX_PREC : precision;
      scale_clamp = (scale > prec) ? prec : scale;
      // sign nibble sits right after the last digit, byte aligned
      sign_idx    = prec | 4'd1;
      sign_nib    = 4'(packed_value >> (6'd60 - {sign_idx, 2'b00}));
      // even precision carries a spare leading nibble
      aligned     = prec[0] ? packed_value : {packed_value[59:0], 4'h0};
      digits      = aligned[63 -: DW];
      ctl.neg     = (sign_nib == SIGN_NEG_B) || (sign_nib == SIGN_NEG_D);
      ctl.prec    = prec;
      ctl.radix   = prec - scale_clamp;
   end

   pdta_fifo #(
      .WIDTH (QW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .wdata ({ctl, digits}),
      .pop   (pop),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   assign head_valid  = !q_empty;
   assign head_ctl    = item_ctl_type'(q_rdata[QW-1:DW]);
   assign head_digits = q_rdata[DW-1:0];

endmodule

>>> rtl/pdta_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdta_back
// Character generator: walks one classified item a step per cycle unless the
// output queue is full; holds a character back to spot the last; queues characters.
// ----------------------------------------------------------------------------
module pdta_back
   import pdta_pkg::*;
#(
   parameter int MAX_DIGITS = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [4:0]              lim,
   input  logic                    head_valid,
   input  item_ctl_type            head_ctl,
   input  logic [4*MAX_DIGITS-1:0] head_digits,
   output logic                    head_pop,
   input  logic                    out_pop,
   output logic                    out_empty,
   output logic [7:0]              out_char,
   output logic                    out_last
);

   localparam int DW = 4 * MAX_DIGITS;

   gen_state_type state_ff;
   gen_state_type state_in;
   logic [3:0]    k_ff;
   logic [4:0]    n_ff;
   logic          printing_ff;
   logic [DW-1:0] digit_ff;
   logic          pend_valid_ff;
   logic [7:0]    pend_char_ff;

   logic          act;
   logic          load;
   logic          emit;
   logic [7:0]    emit_char;
   logic          reached;
   logic          advance;
   logic [3:0]    cur_digit;
   logic [3:0]    k_next;
   logic          out_full;
   logic          out_push;
   logic [8:0]    out_rdata;

   assign act       = !out_full;
   assign cur_digit = digit_ff[DW-1 -: 4];
   assign k_next    = k_ff + 4'd1;
   assign reached   = emit && ((n_ff + 5'd1) == lim);

   // character produced this step
   always_comb begin
      load      = 1'b0;
      emit      = 1'b0;
      emit_char = CHAR_MINUS;
      head_pop  = 1'b0;
      if (act) begin
         unique case (state_ff)
            GEN_SIGN: begin
               if (head_valid) begin
                  load = 1'b1;
                  emit = head_ctl.neg && (lim != 5'd0);
               end
            end
            GEN_LEAD_POINT: begin
               emit      = 1'b1;
               emit_char = CHAR_POINT;
            end
            GEN_DIGIT: begin
               emit      = (cur_digit != 4'd0) || printing_ff;
               emit_char = CHAR_ZERO + {4'd0, cur_digit};
            end
            GEN_ZERO: begin
               emit      = (n_ff == 5'd0);
               emit_char = CHAR_ZERO;
            end
            GEN_POINT: begin
               emit      = 1'b1;
               emit_char = CHAR_POINT;
            end
            GEN_FLUSH: begin
               head_pop = 1'b1;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // next step
   always_comb begin
      state_in = state_ff;
      if (act) begin
         unique case (state_ff)
            GEN_SIGN: begin
               if (head_valid) begin
                  if ((lim == 5'd0) || reached) begin
                     state_in = GEN_FLUSH;
                  end else if (head_ctl.radix == 4'd0) begin
                     state_in = GEN_LEAD_POINT;
                  end else begin
                     state_in = GEN_DIGIT;
                  end
               end
            end
            GEN_LEAD_POINT: begin
               if (reached || (head_ctl.prec == 4'd0)) begin
                  state_in = GEN_FLUSH;
               end else begin
                  state_in = GEN_DIGIT;
               end
            end
            GEN_DIGIT: begin
               priority if (reached) begin
                  state_in = GEN_FLUSH;
               end else if (k_next == head_ctl.radix) begin
                  state_in = GEN_ZERO;
               end else if (k_next == head_ctl.prec) begin
                  state_in = GEN_FLUSH;
               end else begin
                  state_in = GEN_DIGIT;
               end
            end
            GEN_ZERO: begin
               state_in = reached ? GEN_FLUSH : GEN_POINT;
            end
            GEN_POINT: begin
               if (reached || (k_next == head_ctl.prec)) begin
                  state_in = GEN_FLUSH;
               end else begin
                  state_in = GEN_DIGIT;
               end
            end
            GEN_FLUSH: begin
               state_in = GEN_SIGN;
            end
            default: begin
               state_in = GEN_SIGN;
            end
         endcase
      end
   end

   // move to the next digit after a digit step or the point
   assign advance = act && (state_in == GEN_DIGIT)
                    && ((state_ff == GEN_DIGIT) || (state_ff == GEN_POINT));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= GEN_SIGN;
         k_ff          <= 4'd0;
         n_ff          <= 5'd0;
         printing_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (act && (state_ff == GEN_FLUSH)) begin
            k_ff          <= 4'd0;
            n_ff          <= 5'd0;
            printing_ff   <= 1'b0;
            pend_valid_ff <= 1'b0;
         end else begin
            if (emit) begin
               n_ff          <= n_ff + 5'd1;
               pend_valid_ff <= 1'b1;
               // a leading minus does not start digit printing
               if (state_ff != GEN_SIGN) begin
                  printing_ff <= 1'b1;
               end
            end
            if (advance) begin
               k_ff <= k_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pend_char_ff <= emit_char;
      end
      if (load) begin
         digit_ff <= head_digits;
      end else if (advance) begin
         digit_ff <= digit_ff << 4;
      end
   end

   // held character leaves when a newer one arrives or the item ends
   assign out_push = act && pend_valid_ff && (emit || (state_ff == GEN_FLUSH));

   pdta_fifo #(
      .WIDTH (9)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata ({pend_char_ff, (state_ff == GEN_FLUSH)}),
      .pop   (out_pop),
      .empty (out_empty),
      .rdata (out_rdata)
   );

   assign out_char = out_rdata[8:1];
   assign out_last = out_rdata[0];

`ifndef SYNTHESIS
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("character beat pushed into a full output queue");

   a_head_pop_valid: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("item queue popped while empty");

   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != GEN_SIGN) |-> (n_ff <= lim))
      else $error("more characters emitted than the limit allows");

   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GEN_DIGIT) |-> (k_ff < head_ctl.prec))
      else $error("digit step past the last digit");

   a_flush_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GEN_FLUSH) && act |=> (state_ff == GEN_SIGN) && !pend_valid_ff)
      else $error("end of item did not return to the start step");
`endif

endmodule

>>> rtl/packed_decimal_to_ascii_unit.sv
`timescale 1ns / 1ps
// timing: with the generator idle, the first character of a value enters the result
// queue once the next character is produced or the value ends; a run of leading zeros delays it.
// throughput: at most one character per cycle, while the result queue has room; the character
// generator finishes one value before it loads the next, and stalls while the result queue is full.
// reset: synchronous, active high; empties both queues and sets max_chars to 18.
// ----------------------------------------------------------------------------
// packed_decimal_to_ascii_unit
// Converts a packed-decimal value with precision and scale into ASCII text,
// one character per result beat, with the final character flagged.
// ----------------------------------------------------------------------------
module packed_decimal_to_ascii_unit
   import pdta_pkg::*;
#(
   parameter int MAX_DIGITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   // input queue
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_packed_value,
   input  logic [3:0]  req_precision,
   input  logic [3:0]  req_scale,
   // result queue
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [4:0]              max_chars_ff;
   logic [4:0]              lim;
   logic                    csr_wr;
   logic                    head_valid;
   logic                    head_pop;
   item_ctl_type            head_ctl;
   logic [4*MAX_DIGITS-1:0] head_digits;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAX_CHARS) ? {27'd0, max_chars_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else if (csr_wr && (csr_paddr[2] == CSR_IDX_MAX_CHARS)) begin
         max_chars_ff <= csr_pwdata[4:0];
      end
   end

   // room left after the terminator
   assign lim = (max_chars_ff == 5'd0) ? 5'd0 : max_chars_ff - 5'd1;

   pdta_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .packed_value (req_packed_value),
      .precision    (req_precision),
      .scale        (req_scale),
      .pop          (head_pop),
      .head_valid   (head_valid),
      .head_ctl     (head_ctl),
      .head_digits  (head_digits)
   );

   pdta_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .lim         (lim),
      .head_valid  (head_valid),
      .head_ctl    (head_ctl),
      .head_digits (head_digits),
      .head_pop    (head_pop),
      .out_pop     (rsp_pop),
      .out_empty   (rsp_empty),
      .out_char    (rsp_char_code),
      .out_last    (rsp_last)
   );

endmodule

>>> bench/packed_decimal_to_ascii_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_decimal_to_ascii_unit_tb
// Pushes packed-decimal values through the unit and checks every character
// beat against expected text from a directed table or a local formatter.
// The short directed table runs first; after it, random values run under
// several max_chars settings, and both queue sides idle at random.
// ----------------------------------------------------------------------------
module packed_decimal_to_ascii_unit_tb;
   import pdta_pkg::*;

   localparam int DIGIT_LIMIT   = 15;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_VALUES  = 21;

   typedef struct packed {
      logic [7:0] code;
      logic       is_last;
   } char_beat_type;

   typedef struct {
      logic [4:0]  mc;
      logic [63:0] value;
      logic [3:0]  prec;
      logic [3:0]  scale;
      string       text;
   } format_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_packed_value = '0;
   logic [3:0]  req_precision = '0;
   logic [3:0]  req_scale = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_char_code;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   char_beat_type   pending_chars[$];
   format_case_type directed_cases[];
   logic [4:0]   max_chars_now = MAX_CHARS_RESET;
   bit           steady_phase = 1'b0;
   int           mismatch_count = 0;
   int           chars_checked = 0;
   int           values_sent = 0;
   int           settings_used = 1;
   int           cycle_count = 0;

   packed_decimal_to_ascii_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_packed_value (req_packed_value),
      .req_precision    (req_precision),
      .req_scale        (req_scale),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_char_code    (rsp_char_code),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d characters outstanding", $time, pending_chars.size());
         $display("packed_decimal_to_ascii_unit verification failed");
         $finish;
      end
   end

   // nibble 0 sits in bits 63..60
   function automatic logic [3:0] nibble_of(input logic [63:0] v, input int unsigned idx);
      return v[63 - 4 * (idx & 15) -: 4];
   endfunction

   function automatic void format_value(input logic [63:0] v, input logic [3:0] prec_in,
                                        input logic [3:0] scale_in);
      int unsigned prec, scale, radix, skip, lim, n;
      logic [3:0]  sign, d;
      logic [7:0]  text[$];
      bit          printing;
      prec  = (prec_in > DIGIT_LIMIT) ? DIGIT_LIMIT : prec_in;
      scale = (scale_in > prec) ? prec : scale_in;
      radix = prec - scale;
      skip  = (prec % 2 == 1) ? 0 : 1;
      sign  = nibble_of(v, 2 * ((prec + 2) / 2) - 1);
      if (sign == SIGN_NEG_B || sign == SIGN_NEG_D) text.push_back(CHAR_MINUS);
      if (radix == 0) text.push_back(CHAR_POINT);
      printing = (radix == 0);
      for (int unsigned k = 0; k < prec; k++) begin
         d = nibble_of(v, k + skip);
         if (d != 0 || printing) begin
            text.push_back(CHAR_ZERO + 8'(d));
            printing = 1'b1;
         end
         if (k + 1 == radix) begin
            // lone zero only when nothing, not even a minus, came first
            if (text.size() == 0) text.push_back(CHAR_ZERO);
            text.push_back(CHAR_POINT);
            printing = 1'b1;
         end
      end
      lim = (max_chars_now > 0) ? max_chars_now - 1 : 0;
      n = (text.size() > lim) ? lim : text.size();
      for (int unsigned i = 0; i < n; i++)
         pending_chars.push_back('{code: text[i], is_last: (i + 1 == n)});
   endfunction

   task automatic push_value(input logic [63:0] v, input logic [3:0] prec, input logic [3:0] scale,
                             input string text);
      if (!steady_phase && $urandom_range(99) < 9) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_packed_value <= v;
      req_precision    <= prec;
      req_scale        <= scale;
      do @(posedge clock); while (req_full);
      values_sent++;
      if (text.len() == 0) begin
         format_value(v, prec, scale);
      end else begin
         for (int i = 0; i < text.len(); i++)
            pending_chars.push_back('{code: text[i], is_last: (i == text.len() - 1)});
      end
   endtask

   // values cut to nothing still occupy the generator, so wait it out
   task automatic settle_block();
      req_push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_chars(input logic [4:0] mc);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_IDX_MAX_CHARS, 2'b00};
      csr_pwdata  <= 32'(mc);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      max_chars_now = mc;
      settings_used++;
   endtask

   task automatic random_value(output logic [63:0] v, output logic [3:0] prec,
                               output logic [3:0] scale);
      int unsigned lead, skip;
      v     = {$urandom, $urandom};
      prec  = ($urandom_range(19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      scale = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(prec));
      // mostly well-formed digits with a run of leading zeros; spare nibble stays random
      if ($urandom_range(9) < 8) begin
         skip = (prec % 2 == 1) ? 0 : 1;
         lead = $urandom_range(prec);
         for (int unsigned k = 0; k < prec; k++)
            v[63 - 4 * (k + skip) -: 4] = (k < lead) ? 4'd0 : 4'($urandom_range(9));
         v[63 - 4 * (2 * ((prec + 2) / 2) - 1) -: 4] = 4'($urandom_range(10, 15));
      end
   endtask

   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character beat, expected none, got %h last %b",
                     $time, rsp_char_code, rsp_last);
            mismatch_count++;
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (rsp_char_code !== want.code) begin
               $display("%0t: char_code mismatch, expected %h, got %h",
                        $time, want.code, rsp_char_code);
               mismatch_count++;
            end
            if (rsp_last !== want.is_last) begin
               $display("%0t: last mismatch, expected %b, got %b", $time, want.is_last, rsp_last);
               mismatch_count++;
            end
         end
      end
      rsp_pop <= steady_phase || ($urandom_range(99) >= 9);
   end

   initial begin
      logic [63:0] v;
      logic [3:0]  prec, scale;
      logic [4:0]  phase_mc[5];
      directed_cases = '{
         '{5'd18, 64'h123C_0000_0000_0000, 4'd3,  4'd1,  "12.3"},
         '{5'd18, 64'h123D_0000_0000_0000, 4'd3,  4'd1,  "-12.3"},
         '{5'd18, 64'h123B_0000_0000_0000, 4'd3,  4'd1,  "-12.3"},
         '{5'd18, 64'h9999_9999_9999_999C, 4'd15, 4'd0,  "999999999999999."},
         '{5'd18, 64'h9999_9999_9999_999D, 4'd15, 4'd0,  "-999999999999999."},
         '{5'd18, 64'h0000_0000_0000_000D, 4'd15, 4'd15, "-.000000000000000"},
         '{5'd18, 64'h005C_0000_0000_0000, 4'd3,  4'd2,  "0.05"},
         '{5'd18, 64'h005D_0000_0000_0000, 4'd3,  4'd2,  "-.05"},
         '{5'd18, 64'hF123_4C00_0000_0000, 4'd4,  4'd2,  "12.34"},
         '{5'd18, 64'h120C_0000_0000_0000, 4'd3,  4'd9,  ".120"},
         '{5'd18, 64'h0D00_0000_0000_0000, 4'd0,  4'd0,  "-."},
         '{5'd18, 64'h0C00_0000_0000_0000, 4'd0,  4'd5,  "."},
         '{5'd18, 64'hABCD_EC00_0000_0000, 4'd5,  4'd2,  ""},
         '{5'd18, 64'h7C00_0000_0000_0000, 4'd1,  4'd0,  "7."},
         '{5'd18, 64'h7D00_0000_0000_0000, 4'd1,  4'd1,  "-.7"},
         '{5'd18, 64'h0A00_0000_0000_0000, 4'd1,  4'd0,  "0."},
         '{5'd18, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 4'd7,  ""},
         '{5'd18, 64'hFFFF_FFFF_FFFF_FFFF, 4'd14, 4'd14, ""},
         '{5'd18, 64'h0000_0000_0000_0000, 4'd15, 4'd0,  "0."},
         '{5'd18, 64'h042D_0000_0000_0000, 4'd2,  4'd0,  "-42."},
         '{5'd2,  64'h123C_0000_0000_0000, 4'd3,  4'd1,  "1"},
         '{5'd2,  64'h123D_0000_0000_0000, 4'd3,  4'd1,  "-"},
         '{5'd1,  64'h9999_9999_9999_999D, 4'd15, 4'd0,  ""},
         '{5'd0,  64'h123C_0000_0000_0000, 4'd3,  4'd1,  ""},
         '{5'd17, 64'h9999_9999_9999_999D, 4'd15, 4'd0,  ""}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_cases[i]) begin
         if (directed_cases[i].mc != max_chars_now) begin
            settle_block();
            write_max_chars(directed_cases[i].mc);
         end
         push_value(directed_cases[i].value, directed_cases[i].prec,
                    directed_cases[i].scale, directed_cases[i].text);
      end

      phase_mc = '{5'd18, 5'd2, 5'($urandom_range(3, 17)), 5'($urandom_range(3, 17)), 5'd18};
      for (int phase = 0; phase < 5; phase++) begin
         settle_block();
         write_max_chars(phase_mc[phase]);
         // one phase runs both sides without any idling
         steady_phase = (phase == 2);
         for (int i = 0; i < PHASE_VALUES; i++) begin
            random_value(v, prec, scale);
            push_value(v, prec, scale, "");
         end
      end
      steady_phase = 1'b0;
      settle_block();

      if (pending_chars.size() != 0) begin
         $display("%0t: %0d expected characters never arrived", $time, pending_chars.size());
         mismatch_count++;
      end
      $display("converted %0d values (%0d from the directed table) under %0d max_chars settings",
               values_sent, directed_cases.size(), settings_used);
      $display("checked %0d character beats, %0d mismatches", chars_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("packed_decimal_to_ascii_unit verification clean");
      end else begin
         $display("packed_decimal_to_ascii_unit verification failed");
      end
      $finish;
   end

endmodule
